// ----- hdl/rv32_subset_instruction_executor_macros.svh -----
// Assertion macros shared by the checker.
`ifndef RV32_SUBSET_INSTRUCTION_EXECUTOR_MACROS_SVH
`define RV32_SUBSET_INSTRUCTION_EXECUTOR_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define RSIE_ASSERT_IMP(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check an implication on every clock edge, reset included.
`define RSIE_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/rsie_pkg.sv -----
package rsie_pkg;
    localparam int unsigned MemWordsDefault = 32;
    localparam int unsigned XLen = 32;
    localparam int unsigned RegAddrW = 5;

    localparam logic [6:0] OpReg   = 7'b0110011;
    localparam logic [6:0] OpImm   = 7'b0010011;
    localparam logic [6:0] OpLoad  = 7'b0000011;
    localparam logic [6:0] OpStore = 7'b0100011;
    localparam logic [6:0] F7Muld  = 7'b0000001;
    localparam logic [6:0] F7Alt   = 7'b0100000;
    localparam logic [6:0] F7Base  = 7'b0000000;

    localparam logic [2:0] F3Add = 3'd0;
    localparam logic [2:0] F3Slt = 3'd2;
    localparam logic [2:0] F3Div = 3'd4;
    localparam logic [2:0] F3Rem = 3'd6;
    localparam logic [2:0] F3Word = 3'd2;

    typedef enum logic [2:0] {
        OP_NONE, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_REM, OP_SLT, OP_ADDI
    } alu_op_t;
endpackage

// ----- hdl/rv32_subset_instruction_executor.sv -----
// RV32 subset executor: one instruction word per request on the slave side, one
// result per request on the master side. The register file (32 x 32) and the data
// memory (MEM_WORDS x 32) sit in synchronous RAMs with registered reads.
// ADD, SUB, SLT, ADDI, LW and SW pass from acceptance to result through register
// read, decode/execute, memory and write back; MUL adds a step for its registered
// multiplier; DIV and REM use a restoring divider that resolves one quotient bit a
// cycle and then applies the signs. One instruction is in flight at a time; a new
// request is accepted only once the previous result has left the output register,
// which holds until m_tready.
// After reset both memories are cleared by a sweep over max(32, MEM_WORDS)
// addresses, during which s_tready stays low.
module rv32_subset_instruction_executor
    import rsie_pkg::*;
#(
    parameter int unsigned MEM_WORDS = MemWordsDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // [31:0] instruction
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] recognized, [1] reg_written, [6:2] dest_reg, [38:7] write_value,
    // [39] mem_written, [44:40] mem_index, [47:45] zero
    output logic [47:0] m_tdata
);
    localparam int unsigned MemAw = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam int unsigned ClrN  = (MEM_WORDS > 32) ? MEM_WORDS : 32;
    localparam int unsigned ClrW  = $clog2(ClrN) + 1;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_READ, S_EXEC, S_MUL, S_DIV, S_MEM, S_OUT
    } state_t;

    state_t state_reg;
    logic [ClrW-1:0] clr_reg;
    logic [31:0] ins_reg;
    logic [31:0] rf_mem [32];
    logic [31:0] dm_mem [MEM_WORDS];
    logic [31:0] a_reg, b_reg, dm_rd_reg;
    logic [31:0] val_reg;
    logic [31:0] prod_reg;
    logic [31:0] quo_reg, rem_reg, dvs_reg;
    logic [5:0]  cnt_reg;
    logic        neg_q_reg, neg_r_reg, dz_reg;
    alu_op_t     op_reg;
    logic        recog_reg, wreg_reg, wmem_reg, used_reg;
    logic [MemAw-1:0] idx_reg;
    logic        out_valid_reg;
    logic [47:0] out_data_reg;

    logic [6:0] opc, f7;
    logic [2:0] f3;
    logic [4:0] rd, rs1, rs2;
    assign opc = ins_reg[6:0];
    assign rd  = ins_reg[11:7];
    assign f3  = ins_reg[14:12];
    assign rs1 = ins_reg[19:15];
    assign rs2 = ins_reg[24:20];
    assign f7  = ins_reg[31:25];

    logic [31:0] imm_i, imm_s, addr;
    logic        in_range, is_load, is_store;
    alu_op_t     dec_op;
    assign imm_i = {{20{ins_reg[31]}}, ins_reg[31:20]};
    assign imm_s = {{20{ins_reg[31]}}, ins_reg[31:25], ins_reg[11:7]};
    assign is_load  = (opc == OpLoad) && (f3 == F3Word);
    assign is_store = (opc == OpStore) && (f3 == F3Word);
    assign addr = a_reg + (is_store ? imm_s : imm_i);
    assign in_range = ({32'd0, addr} < 64'(MEM_WORDS));

    always_comb begin
        dec_op = OP_NONE;
        if (opc == OpReg) begin
            priority if (f7 == F7Base && f3 == F3Add) dec_op = OP_ADD;
            else if (f7 == F7Alt && f3 == F3Add)  dec_op = OP_SUB;
            else if (f7 == F7Muld && f3 == F3Add) dec_op = OP_MUL;
            else if (f7 == F7Muld && f3 == F3Div) dec_op = OP_DIV;
            else if (f7 == F7Muld && f3 == F3Rem) dec_op = OP_REM;
            else if (f7 == F7Base && f3 == F3Slt) dec_op = OP_SLT;
            else dec_op = OP_NONE;
        end else if (opc == OpImm && f3 == F3Add) begin
            dec_op = OP_ADDI;
        end
    end

    // Divider step: shift remainder in one dividend bit, try subtract.
    logic [32:0] trial;
    logic [31:0] rem_sh;
    assign rem_sh = {rem_reg[30:0], quo_reg[31]};
    assign trial  = {1'b0, rem_sh} - {1'b0, dvs_reg};

    logic [31:0] abs_a, abs_b;
    assign abs_a = a_reg[31] ? (32'd0 - a_reg) : a_reg;
    assign abs_b = b_reg[31] ? (32'd0 - b_reg) : b_reg;

    assign s_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    logic do_rf_wr, do_dm_wr;
    logic [4:0] rf_wa;
    logic [MemAw-1:0] dm_wa;
    logic [31:0] rf_wd, dm_wd;
    always_comb begin
        // a load writes back the word fetched from the data memory
        do_rf_wr = 1'b0; rf_wa = rd; rf_wd = (is_load && used_reg) ? dm_rd_reg : val_reg;
        do_dm_wr = 1'b0; dm_wa = idx_reg; dm_wd = b_reg;
        if (state_reg == S_CLEAR) begin
            do_rf_wr = (clr_reg < ClrW'(32));
            rf_wa = clr_reg[4:0];
            rf_wd = '0;
            do_dm_wr = (clr_reg < ClrW'(MEM_WORDS));
            dm_wa = clr_reg[MemAw-1:0];
            dm_wd = '0;
        end else if (state_reg == S_OUT) begin
            do_rf_wr = wreg_reg;
            do_dm_wr = wmem_reg;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg <= rf_mem[s_tready ? s_tdata[19:15] : rs1];
        b_reg <= rf_mem[s_tready ? s_tdata[24:20] : rs2];
        dm_rd_reg <= dm_mem[idx_reg];
        if (do_rf_wr) rf_mem[rf_wa] <= rf_wd;
        if (do_dm_wr) dm_mem[dm_wa] <= dm_wd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && m_tready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == ClrW'(ClrN - 1)) state_reg <= S_IDLE;
                end
                S_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        ins_reg <= s_tdata;
                        state_reg <= S_READ;
                    end
                end
                S_READ: begin
                    // operands arrive from the register file RAM this cycle
                    state_reg <= S_EXEC;
                end
                S_EXEC: begin
                    op_reg <= dec_op;
                    recog_reg <= (dec_op != OP_NONE) || is_load || is_store;
                    wreg_reg <= 1'b0;
                    wmem_reg <= 1'b0;
                    used_reg <= 1'b0;
                    idx_reg <= addr[MemAw-1:0];
                    val_reg <= '0;
                    state_reg <= S_MEM;
                    unique case (dec_op)
                        OP_ADD:  begin val_reg <= a_reg + b_reg; wreg_reg <= (rd != 0); end
                        OP_SUB:  begin val_reg <= a_reg - b_reg; wreg_reg <= (rd != 0); end
                        OP_SLT:  begin
                            val_reg <= {31'd0, $signed(a_reg) < $signed(b_reg)};
                            wreg_reg <= (rd != 0);
                        end
                        OP_ADDI: begin val_reg <= a_reg + imm_i; wreg_reg <= (rd != 0); end
                        OP_MUL:  begin
                            // low 32 bits of the product only
                            prod_reg <= a_reg * b_reg;
                            wreg_reg <= (rd != 0);
                            state_reg <= S_MUL;
                        end
                        OP_DIV, OP_REM: begin
                            quo_reg <= abs_a;
                            rem_reg <= '0;
                            dvs_reg <= abs_b;
                            dz_reg <= (b_reg == 0);
                            neg_q_reg <= a_reg[31] ^ b_reg[31];
                            neg_r_reg <= a_reg[31];
                            cnt_reg <= '0;
                            wreg_reg <= (rd != 0);
                            state_reg <= S_DIV;
                        end
                        OP_NONE: begin
                            if ((is_load || is_store) && in_range) begin
                                used_reg <= 1'b1;
                                wreg_reg <= is_load && (rd != 0);
                                wmem_reg <= is_store;
                            end
                        end
                        default: ;
                    endcase
                end
                S_MUL: begin
                    val_reg <= prod_reg;
                    state_reg <= S_MEM;
                end
                S_DIV: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 6'd32) begin
                        // apply signs; x/0 and x%0 give 0
                        if (dz_reg) val_reg <= '0;
                        else if (op_reg == OP_DIV)
                            val_reg <= neg_q_reg ? (32'd0 - quo_reg) : quo_reg;
                        else
                            val_reg <= neg_r_reg ? (32'd0 - rem_reg) : rem_reg;
                        state_reg <= S_MEM;
                    end else begin
                        if (!trial[32]) begin
                            rem_reg <= trial[31:0];
                            quo_reg <= {quo_reg[30:0], 1'b1};
                        end else begin
                            rem_reg <= rem_sh;
                            quo_reg <= {quo_reg[30:0], 1'b0};
                        end
                    end
                end
                S_MEM: begin
                    // load data from the data memory RAM is available next cycle
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (is_load && used_reg) val_reg <= dm_rd_reg;
                    out_valid_reg <= 1'b1;
                    out_data_reg <= {3'd0,
                        used_reg ? 5'(idx_reg) : 5'd0,
                        wmem_reg,
                        wreg_reg ? ((is_load && used_reg) ? dm_rd_reg : val_reg) : 32'd0,
                        wreg_reg ? rd : 5'd0,
                        wreg_reg, recog_reg};
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- hdl/rsie_checker.sv -----
`include "rv32_subset_instruction_executor_macros.svh"
module rsie_checker
    import rsie_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);
    `RSIE_ASSERT_IMP(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result dropped while stalled")
    `RSIE_ASSERT_IMP(a_wr_recog, aclk, aresetn, m_tvalid && (m_tdata[1] || m_tdata[39]) |-> m_tdata[0], "write from unrecognized instruction")
    `RSIE_ASSERT_IMP(a_x0, aclk, aresetn, m_tvalid && m_tdata[1] |-> m_tdata[6:2] != 5'd0, "write to x0 reported")
    `RSIE_ASSERT_IMP(a_one, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "second request taken while busy")
    `RSIE_ASSERT_ALWAYS(a_rst, aclk, !aresetn |=> !m_tvalid && !s_tready, "handshake active after reset")
endmodule

bind rv32_subset_instruction_executor rsie_checker u_rsie_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
